@@ src/taq_pkg.sv @@
// Shared types and constants for the two-class age-ordered queue.
package taq_pkg;

	localparam int PAY_W = 32;
	localparam int TAG_W = 6;

	typedef enum logic [1:0] {
		KIND_ADD      = 2'd0,
		KIND_POLL_ANY = 2'd1,
		KIND_POLL_DOG = 2'd2,
		KIND_POLL_CAT = 2'd3
	} kind_t;

	typedef struct packed {
		logic [PAY_W-1:0] payload;
		logic [TAG_W-1:0] tag;
	} cell_data_t;

	typedef struct packed {
		logic push;
		logic pop;
	} fifo_ctl_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic single;
	} fifo_sts_t;

endpackage

@@ src/taq_cell.sv @@
// One storage cell of a shifting queue: loads a new entry or takes its neighbor's.
module taq_cell (
	input  logic                clk,
	input  logic                load,
	input  logic                shift,
	input  taq_pkg::cell_data_t new_data,
	input  taq_pkg::cell_data_t next_data,
	output taq_pkg::cell_data_t data_q
);
	import taq_pkg::*;

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= next_data;
		end else if (load) begin
			data_q <= new_data;
		end
	end

endmodule

@@ src/taq_chain.sv @@
// Shifting queue built from a row of cells; the head sits in cell zero.
module taq_chain #(
	parameter int DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  taq_pkg::fifo_ctl_t  ctl,
	input  taq_pkg::cell_data_t wr_data,
	output taq_pkg::cell_data_t head,
	output taq_pkg::fifo_sts_t  sts
);
	import taq_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0] count_q;
	cell_data_t       cell_d [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_data_t nbr;
		if (i == DEPTH - 1) begin : g_last
			assign nbr = cell_d[i];
		end else begin : g_mid
			assign nbr = cell_d[i+1];
		end
		taq_cell u_cell (
			.clk       (clk),
			.load      (ctl.push && (count_q == CNT_W'(i))),
			.shift     (ctl.pop),
			.new_data  (wr_data),
			.next_data (nbr),
			.data_q    (cell_d[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.push) begin
			count_q <= count_q + CNT_W'(1);
		end else if (ctl.pop) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	assign head       = cell_d[0];
	assign sts.empty  = (count_q == '0);
	assign sts.full   = (count_q == CNT_W'(DEPTH));
	assign sts.single = (count_q == CNT_W'(1));

endmodule

@@ src/two_class_age_ordered_queue_top.sv @@
// Top level of the two-class age-ordered queue.
//
// Input items arrive on s_axis: tuser carries the kind (add, poll oldest,
// poll class 0, poll class 1) and the class of an added item, tdata the
// payload. Every item gives exactly one result item on m_axis: tuser holds
// found and the class of the removed item, tdata the removed payload, the
// overflow flag and the three empty flags as they stand after the item.
// Each class keeps a row of cells that shifts toward the head on a poll;
// an add writes the cell at the fill count. A shared 6-bit arrival tag is
// compared modulo 64 to pick the older head on a poll for the oldest item.
// Result valid is registered and rises in the cycle after input accept.
// One item per cycle is taken while the result register is empty or
// being drained. When the receiver stalls, s_axis_tready drops until
// the held result is taken. Reset clears the fill counts, the tag
// counter and the result valid flag; queue contents need no clearing
// and the block is ready as soon as reset is released.
module two_class_age_ordered_queue_top #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // payload[31:0]
	input  logic [2:0]  s_axis_tuser,  // kind[1:0], item_class[2]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // out_payload[31:0], overflow[32], all_empty[33],
	                                   // dog_empty[34], cat_empty[35], zero[39:36]
	output logic [1:0]  m_axis_tuser   // found[0], out_class[1]
);
	import taq_pkg::*;

	logic             acc;
	kind_t            kind;
	logic             cls;
	logic             take_dog, take_cat, add_dog, add_cat, ovf;
	logic [TAG_W-1:0] tag_diff;
	logic [TAG_W-1:0] next_tag_q;
	fifo_ctl_t        dog_ctl, cat_ctl;
	fifo_sts_t        dog_sts, cat_sts;
	cell_data_t       dog_head, cat_head, wr_data;
	logic             dog_empty_n, cat_empty_n;
	logic             out_valid_q;
	logic             found_q, out_class_q, ovf_q;
	logic             dog_empty_q, cat_empty_q;
	logic [PAY_W-1:0] out_payload_q;
	logic [PAY_W-1:0] sel_payload;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign kind          = kind_t'(s_axis_tuser[1:0]);
	assign cls           = s_axis_tuser[2];
	assign tag_diff      = cat_head.tag - dog_head.tag;

	always_comb begin
		take_dog = 1'b0;
		take_cat = 1'b0;
		add_dog  = 1'b0;
		add_cat  = 1'b0;
		ovf      = 1'b0;
		unique case (kind)
			KIND_ADD: begin
				if (cls) begin
					ovf     = cat_sts.full;
					add_cat = !cat_sts.full;
				end else begin
					ovf     = dog_sts.full;
					add_dog = !dog_sts.full;
				end
			end
			KIND_POLL_ANY: begin
				if (!dog_sts.empty && !cat_sts.empty) begin
					take_dog = (tag_diff != '0) && !tag_diff[TAG_W-1];
					take_cat = !take_dog;
				end else begin
					take_dog = !dog_sts.empty;
					take_cat = !cat_sts.empty;
				end
			end
			KIND_POLL_DOG: take_dog = !dog_sts.empty;
			KIND_POLL_CAT: take_cat = !cat_sts.empty;
			default: ;
		endcase
	end

	assign dog_ctl.push = acc && add_dog;
	assign dog_ctl.pop  = acc && take_dog;
	assign cat_ctl.push = acc && add_cat;
	assign cat_ctl.pop  = acc && take_cat;

	assign wr_data.payload = s_axis_tdata;
	assign wr_data.tag     = next_tag_q;

	taq_chain #(.DEPTH(QUEUE_DEPTH)) u_dog (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (dog_ctl),
		.wr_data (wr_data),
		.head    (dog_head),
		.sts     (dog_sts)
	);

	taq_chain #(.DEPTH(QUEUE_DEPTH)) u_cat (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (cat_ctl),
		.wr_data (wr_data),
		.head    (cat_head),
		.sts     (cat_sts)
	);

	assign dog_empty_n = dog_sts.empty ? !add_dog : (take_dog && dog_sts.single);
	assign cat_empty_n = cat_sts.empty ? !add_cat : (take_cat && cat_sts.single);
	assign sel_payload = take_dog ? dog_head.payload :
	                     take_cat ? cat_head.payload : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_tag_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc && (add_dog || add_cat)) begin
				next_tag_q <= next_tag_q + TAG_W'(1);
			end
			if (acc) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			found_q       <= take_dog || take_cat;
			out_class_q   <= take_cat;
			out_payload_q <= sel_payload;
			ovf_q         <= ovf;
			dog_empty_q   <= dog_empty_n;
			cat_empty_q   <= cat_empty_n;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, cat_empty_q, dog_empty_q, dog_empty_q && cat_empty_q,
	                        ovf_q, out_payload_q};
	assign m_axis_tuser  = {out_class_q, found_q};

endmodule

@@ tb/two_class_age_ordered_queue_top_tb.sv @@
// Self-checking testbench: random and directed adds and polls against a shadow model of both queues.
`timescale 1ns / 1ps

module two_class_age_ordered_queue_top_tb;

	import taq_pkg::*;

	localparam int DEPTH        = 16;
	localparam int TAG_HALF     = 32;
	localparam int IDLE_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 10;
	localparam int RANDOM_OPS   = 1200;
	localparam int NO_TAKE      = -1;
	localparam bit DOG          = 1'b0;
	localparam bit CAT          = 1'b1;

	typedef struct {
		kind_t       kind;
		logic        cls;
		logic [31:0] payload;
		bit          drain;
	} queue_op_t;

	typedef struct {
		logic        found;
		logic [31:0] payload;
		logic        cls;
		logic        ovf;
		logic        all_empty;
		logic        dog_empty;
		logic        cat_empty;
	} queue_reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic [2:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	queue_op_t    pending_ops[$];
	queue_reply_t due_replies[$];

	logic [31:0] shadow_pay[2][DEPTH];
	logic [5:0]  shadow_tag[2][DEPTH];
	int          shadow_head[2];
	int          shadow_fill[2];
	logic [5:0]  shadow_next_tag;

	int mismatches;
	int idle_cycles;
	int send_gap;
	int send_calm;
	int recv_hold;
	int recv_calm;
	queue_op_t    next_op;
	queue_reply_t want;

	two_class_age_ordered_queue_top #(
		.QUEUE_DEPTH(DEPTH)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic queue_reply_t step_shadow_queues(kind_t kind, logic cls,
			logic [31:0] payload);
		queue_reply_t res;
		int           take;
		int           slot;
		logic [5:0]   age_gap;
		res  = '{default: '0};
		take = NO_TAKE;
		case (kind)
			KIND_ADD: begin
				if (shadow_fill[cls] == DEPTH) begin
					res.ovf = 1'b1;
				end else begin
					slot = (shadow_head[cls] + shadow_fill[cls]) % DEPTH;
					shadow_pay[cls][slot] = payload;
					shadow_tag[cls][slot] = shadow_next_tag;
					shadow_fill[cls]++;
					shadow_next_tag = shadow_next_tag + 6'd1;
				end
			end
			KIND_POLL_ANY: begin
				if (shadow_fill[DOG] != 0 && shadow_fill[CAT] != 0) begin
					age_gap = shadow_tag[CAT][shadow_head[CAT]]
						- shadow_tag[DOG][shadow_head[DOG]];
					take = (age_gap != 0 && age_gap < TAG_HALF) ? int'(DOG) : int'(CAT);
				end else if (shadow_fill[DOG] != 0) begin
					take = int'(DOG);
				end else if (shadow_fill[CAT] != 0) begin
					take = int'(CAT);
				end
			end
			KIND_POLL_DOG: begin
				if (shadow_fill[DOG] != 0)
					take = int'(DOG);
			end
			KIND_POLL_CAT: begin
				if (shadow_fill[CAT] != 0)
					take = int'(CAT);
			end
		endcase
		if (take != NO_TAKE) begin
			res.found   = 1'b1;
			res.payload = shadow_pay[take][shadow_head[take]];
			res.cls     = take[0];
			shadow_head[take] = (shadow_head[take] + 1) % DEPTH;
			shadow_fill[take]--;
		end
		res.dog_empty = (shadow_fill[DOG] == 0);
		res.cat_empty = (shadow_fill[CAT] == 0);
		res.all_empty = res.dog_empty && res.cat_empty;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: mismatch on %s: expected %h, got %h", $time, what, exp_val, act_val);
	endtask

	task automatic add_op(input kind_t kind, input logic cls, input logic [31:0] payload,
			input bit drain);
		queue_op_t op;
		op.kind    = kind;
		op.cls     = cls;
		op.payload = payload;
		op.drain   = drain;
		pending_ops.push_back(op);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= '0;
			send_gap       = 0;
			send_calm      = 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (send_gap > 0) begin
				send_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_ops.size() != 0 && pending_ops[0].drain
					&& (s_axis_tvalid || due_replies.size() != 0)) begin
				s_axis_tvalid <= 1'b0;
			end else if (pending_ops.size() != 0) begin
				next_op = pending_ops.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= next_op.payload;
				s_axis_tuser  <= {next_op.cls, next_op.kind};
				if (send_calm > 0) begin
					send_calm--;
					send_gap = 0;
				end else if ($urandom_range(0, 99) < 2) begin
					send_calm = $urandom_range(30, 80);
					send_gap  = 0;
				end else begin
					send_gap = pick_gap();
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_hold      = 0;
			recv_calm      = 0;
		end else if (recv_hold > 0) begin
			recv_hold--;
			m_axis_tready <= 1'b0;
		end else if (recv_calm > 0) begin
			recv_calm--;
			m_axis_tready <= 1'b1;
		end else if ($urandom_range(0, 99) < 3) begin
			recv_calm = $urandom_range(30, 100);
			m_axis_tready <= 1'b1;
		end else if ($urandom_range(0, 99) < 30) begin
			recv_hold = pick_gap();
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (due_replies.size() == 0) begin
					report_mismatch("unexpected result", '0, m_axis_tdata[31:0]);
				end else begin
					want = due_replies.pop_front();
					if (m_axis_tuser[0] !== want.found)
						report_mismatch("found", 32'(want.found), 32'(m_axis_tuser[0]));
					if (m_axis_tdata[31:0] !== want.payload)
						report_mismatch("out_payload", want.payload, m_axis_tdata[31:0]);
					if (m_axis_tuser[1] !== want.cls)
						report_mismatch("out_class", 32'(want.cls), 32'(m_axis_tuser[1]));
					if (m_axis_tdata[32] !== want.ovf)
						report_mismatch("overflow", 32'(want.ovf), 32'(m_axis_tdata[32]));
					if (m_axis_tdata[33] !== want.all_empty)
						report_mismatch("all_empty", 32'(want.all_empty),
							32'(m_axis_tdata[33]));
					if (m_axis_tdata[34] !== want.dog_empty)
						report_mismatch("dog_empty", 32'(want.dog_empty),
							32'(m_axis_tdata[34]));
					if (m_axis_tdata[35] !== want.cat_empty)
						report_mismatch("cat_empty", 32'(want.cat_empty),
							32'(m_axis_tdata[35]));
					if (m_axis_tdata[39:36] !== 4'b0)
						report_mismatch("pad bits", '0, 32'(m_axis_tdata[39:36]));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				due_replies.push_back(step_shadow_queues(kind_t'(s_axis_tuser[1:0]),
					s_axis_tuser[2], s_axis_tdata));
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		int    produced;
		int    run_len;
		int    add_pct;
		kind_t kind;
		mismatches      = 0;
		idle_cycles     = 0;
		shadow_head     = '{0, 0};
		shadow_fill     = '{0, 0};
		shadow_next_tag = '0;
		// polls on empty queues
		add_op(KIND_POLL_ANY, CAT, 32'hFFFF_FFFF, 1'b0);
		add_op(KIND_POLL_DOG, CAT, 32'h0000_0000, 1'b0);
		add_op(KIND_POLL_CAT, DOG, 32'hFFFF_FFFF, 1'b0);
		// age order across classes, then class polls
		add_op(KIND_ADD, DOG, 32'h0000_0000, 1'b0);
		add_op(KIND_ADD, CAT, 32'hFFFF_FFFF, 1'b0);
		add_op(KIND_ADD, DOG, 32'h1234_5678, 1'b0);
		add_op(KIND_POLL_ANY, DOG, '0, 1'b0);
		add_op(KIND_POLL_ANY, DOG, '0, 1'b0);
		add_op(KIND_POLL_DOG, CAT, '0, 1'b0);
		// fill class 1 to the brim, then overflow it
		for (int i = 0; i <= DEPTH; i++)
			add_op(KIND_ADD, CAT, $urandom, 1'b0);
		produced = 0;
		while (produced < RANDOM_OPS) begin
			case ($urandom_range(0, 3))
				0: add_pct = 15;
				1: add_pct = 50;
				2: add_pct = 85;
				default: add_pct = 97;
			endcase
			run_len = $urandom_range(20, 60);
			for (int i = 0; i < run_len; i++) begin
				if ($urandom_range(0, 99) < add_pct)
					kind = KIND_ADD;
				else
					kind = kind_t'($urandom_range(1, 3));
				add_op(kind, 1'($urandom_range(0, 1)), $urandom,
					(produced == 0 && i == 0) || $urandom_range(0, 99) == 0);
			end
			produced += run_len;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (pending_ops.size() != 0 || s_axis_tvalid || due_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
